>>> hdl/lfat_pkg.sv
// Shared types, constants and the cell update rule for the fading-trail life block.
// No dependencies; imported by the top level, the port checker and the testbench.
`timescale 1ns / 1ps

package lfat_pkg;

    // Default grid size
    localparam int DEF_GRID_COLS = 64;
    localparam int DEF_GRID_ROWS = 64;

    // Cell encoding: 1 alive, 0 down to -4 trail age
    localparam int                 CELL_W      = 3;
    localparam logic signed [2:0]  CELL_ALIVE  = 3'sd1;
    localparam logic signed [2:0]  CELL_EMPTY  = 3'sd0;
    localparam logic signed [2:0]  TRAIL_FLOOR = -3'sd4;

    // Neighbor counts of the rule
    localparam logic [3:0] SURVIVE_LO = 4'd2;
    localparam logic [3:0] SURVIVE_HI = 4'd3;
    localparam logic [3:0] BIRTH_CNT  = 4'd3;

    // Stream beat layout
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;
    localparam int GEN_W     = 16;

    // Register select, taken from paddr[2]
    localparam logic REG_ACTIVE_WIDTH  = 1'b0;
    localparam logic REG_ACTIVE_HEIGHT = 1'b1;
    localparam int   CFG_W             = 7;
    localparam logic [CFG_W-1:0] SIZE_MIN = 7'd3;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STEP  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_STEP,
        ST_RESP
    } t_state;

    // Next value of one cell from its value and its live-neighbor count
    function automatic logic signed [2:0] f_next_cell(input logic signed [2:0] cur,
                                                      input logic [3:0] cnt);
        logic alive;
        logic signed [2:0] nxt;
        alive = (cur > CELL_EMPTY);
        nxt   = (cur > TRAIL_FLOOR) ? cur - 3'sd1 : TRAIL_FLOOR;
        if (alive && (cnt == SURVIVE_LO || cnt == SURVIVE_HI)) begin
            nxt = CELL_ALIVE;
        end
        if (!alive && cnt == BIRTH_CNT) begin
            nxt = CELL_ALIVE;
        end
        return nxt;
    endfunction

endpackage

>>> hdl/lfat_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lfat_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/life_automaton_with_fading_trail.sv
// Top level of the fading-trail life block: command stream, APB registers, two grid banks.
// Depends on lfat_pkg and lfat_ram.
`timescale 1ns / 1ps
//
// Usage
//   Command beats arrive on the slave stream (i_s_*), one result beat per command
//   leaves on the master stream (o_m_*). Commands: write cell, read cell, advance
//   one generation. The APB port sets the active width and height (clamped to
//   3 .. grid size). The user must see that it is written only while the block
//   is idle; the block itself does not enforce this. A step is a raster sweep:
//   one read of the source bank and one write of the destination bank per cell,
//   through a window of two grid rows plus three shift taps.
//   One command is in work at a time; o_s_tready is high only when idle.
//   Reset: a clearing pass zeroes both banks, during which no command is
//   accepted. Bank a is current and the generation is zero.
//   Stall: a finished result waits in the output register; the next command is
//   accepted meanwhile, and its result is held back until that register frees.
//
module life_automaton_with_fading_trail
    import lfat_pkg::*;
#(
    parameter int GRID_COLS = DEF_GRID_COLS,
    parameter int GRID_ROWS = DEF_GRID_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [1:0] operation, [7:2] col, [13:8] row, [16:14] cell_value, [23:17] zero
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // result stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [2:0] read_value, [18:3] generation, [23:19] zero
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // APB registers
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int CELLS    = GRID_COLS * GRID_ROWS;
    localparam int AW       = $clog2(CELLS);
    localparam int LEAD_END = CELLS + GRID_COLS;
    localparam int LW       = $clog2(LEAD_END + 1);
    localparam int CCW      = $clog2(GRID_COLS);
    localparam int CRW      = $clog2(GRID_ROWS);
    localparam int LRW      = $clog2(GRID_ROWS + 2);
    localparam int WIN      = 2 * GRID_COLS + 3;
    localparam int CMP_W    = $clog2(GRID_COLS + GRID_ROWS + 256);
    localparam int PW       = AW + 7;
    localparam int MID      = GRID_COLS;
    localparam int TOP      = 2 * GRID_COLS;
    localparam logic [CFG_W-1:0] W_RST = CFG_W'((GRID_COLS < 64) ? GRID_COLS : 64);
    localparam logic [CFG_W-1:0] H_RST = CFG_W'((GRID_ROWS < 64) ? GRID_ROWS : 64);

    // Interior test against the active area
    function automatic logic f_interior(input logic [CMP_W-1:0] c,
                                        input logic [CMP_W-1:0] r,
                                        input logic [CFG_W-1:0] w,
                                        input logic [CFG_W-1:0] h);
        return (c >= CMP_W'(1)) && (r >= CMP_W'(1)) &&
               (c + CMP_W'(1) < CMP_W'(w)) && (r + CMP_W'(1) < CMP_W'(h));
    endfunction

    // Register clamp to 3 .. limit
    function automatic logic [CFG_W-1:0] f_clamp(input logic [CFG_W-1:0] v,
                                                 input logic [CMP_W-1:0] lim);
        logic [CFG_W-1:0] res;
        res = v;
        if (v < SIZE_MIN) begin
            res = SIZE_MIN;
        end else if (CMP_W'(v) > lim) begin
            res = lim[CFG_W-1:0];
        end
        return res;
    endfunction

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_aw, r_ah;
    logic             r_cur;
    logic [GEN_W-1:0] r_gen;
    logic [AW-1:0]    r_clr_addr;

    // step sweep: lead (read) side
    logic             r_lead_on;
    logic [LW-1:0]    r_lead;
    logic [CCW-1:0]   r_lc;
    logic [LRW-1:0]   r_lr;
    logic             r_s1_vld, r_s1_int, r_s1_wr;
    // step sweep: center (write) side
    logic             r_s2_vld;
    logic [AW-1:0]    r_caddr;
    logic [CCW-1:0]   r_cc;
    logic [CRW-1:0]   r_cr;
    logic signed [2:0] r_win [WIN];

    logic              r_rd_int;
    logic signed [2:0] r_res;
    logic              r_out_vld;
    logic signed [2:0] r_out_val;
    logic [GEN_W-1:0]  r_out_gen;

    // command fields
    t_op               cmd_op;
    logic [5:0]        cmd_col, cmd_row;
    logic signed [2:0] cmd_val, wr_val;
    logic [PW-1:0]     cell_prod;
    logic [AW-1:0]     cell_addr;
    logic              cell_int;

    logic s_ready, accept, rd_cap, out_load, clearing, clr_last, issue, step_done;
    logic cell_wr, cfg_wr;

    logic              we_a, we_b;
    logic [AW-1:0]     waddr, raddr;
    logic signed [2:0] wdata, nxt_cell, cur_cell, shift_in;
    logic [2:0]        rdata_a, rdata_b;
    logic signed [2:0] rdata_cur;
    logic [3:0]        live_cnt;
    logic              c_int;

    assign cmd_op  = t_op'(i_s_tdata[1:0]);
    assign cmd_col = i_s_tdata[7:2];
    assign cmd_row = i_s_tdata[13:8];
    assign cmd_val = i_s_tdata[16:14];
    assign wr_val  = (cmd_val > CELL_ALIVE) ? CELL_ALIVE : cmd_val;

    assign cell_prod = PW'(cmd_row) * PW'(GRID_COLS) + PW'(cmd_col);
    assign cell_addr = cell_prod[AW-1:0];
    assign cell_int  = f_interior(CMP_W'(cmd_col), CMP_W'(cmd_row), r_aw, r_ah);

    assign accept    = i_s_tvalid && s_ready;
    assign cell_wr   = accept && (cmd_op == OP_WRITE) && cell_int;
    assign clearing  = (r_state == ST_CLEAR);
    assign clr_last  = (r_clr_addr == AW'(CELLS - 1));
    assign issue     = (r_state == ST_STEP) && r_lead_on;
    assign step_done = r_s2_vld && (r_caddr == AW'(CELLS - 1));

    // FSM next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (clr_last) n_state = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    unique case (cmd_op)
                        OP_READ:  n_state = ST_READ;
                        OP_STEP:  n_state = ST_STEP;
                        OP_WRITE,
                        OP_NONE:  n_state = ST_RESP;
                        default:  n_state = ST_RESP;
                    endcase
                end
            end
            ST_READ:  n_state = ST_RESP;
            ST_STEP:  if (step_done) n_state = ST_RESP;
            ST_RESP:  if (out_load) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_ready  = 1'b0;
        rd_cap   = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: s_ready  = 1'b1;
            ST_READ: rd_cap   = 1'b1;
            ST_RESP: out_load = !r_out_vld || i_m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // reset clearing pass over both banks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (clearing && !clr_last) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aw <= W_RST;
            r_ah <= H_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_ACTIVE_WIDTH:  r_aw <= f_clamp(pwdata[CFG_W-1:0], CMP_W'(GRID_COLS));
                REG_ACTIVE_HEIGHT: r_ah <= f_clamp(pwdata[CFG_W-1:0], CMP_W'(GRID_ROWS));
                default: ;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ACTIVE_HEIGHT) ? {25'd0, r_ah} : {25'd0, r_aw};

    // bank select and generation count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= 1'b0;
            r_gen <= '0;
        end else if (step_done) begin
            r_cur <= !r_cur;
            r_gen <= r_gen + GEN_W'(1);
        end
    end

    // lead counters: read the source bank in raster order, GRID_COLS+1 beyond the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_on <= 1'b0;
            r_lead    <= '0;
            r_lc      <= '0;
            r_lr      <= '0;
        end else if (accept && cmd_op == OP_STEP) begin
            r_lead_on <= 1'b1;
            r_lead    <= '0;
            r_lc      <= '0;
            r_lr      <= '0;
        end else if (issue) begin
            r_lead <= r_lead + LW'(1);
            if (r_lead == LW'(LEAD_END)) begin
                r_lead_on <= 1'b0;
            end
            if (r_lc == CCW'(GRID_COLS - 1)) begin
                r_lc <= '0;
                r_lr <= r_lr + LRW'(1);
            end else begin
                r_lc <= r_lc + CCW'(1);
            end
        end
    end

    // read-data stage tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld && r_s1_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_int <= (r_lead < LW'(CELLS)) &&
                    f_interior(CMP_W'(r_lc), CMP_W'(r_lr), r_aw, r_ah);
        r_s1_wr  <= (r_lead >= LW'(GRID_COLS + 1));
    end

    // window shift line: tap k holds the cell read k beats earlier
    assign rdata_cur = r_cur ? rdata_b : rdata_a;
    assign shift_in  = r_s1_int ? rdata_cur : CELL_EMPTY;

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_win[0] <= shift_in;
            for (int k = 1; k < WIN; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    // center counters: one destination write per beat of the sweep once r_s1_wr is set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caddr <= '0;
            r_cc    <= '0;
            r_cr    <= '0;
        end else if (accept && cmd_op == OP_STEP) begin
            r_caddr <= '0;
            r_cc    <= '0;
            r_cr    <= '0;
        end else if (r_s2_vld) begin
            r_caddr <= r_caddr + AW'(1);
            if (r_cc == CCW'(GRID_COLS - 1)) begin
                r_cc <= '0;
                r_cr <= r_cr + CRW'(1);
            end else begin
                r_cc <= r_cc + CCW'(1);
            end
        end
    end

    // neighbor count and cell rule
    always_comb begin
        live_cnt = 4'(r_win[0] > CELL_EMPTY) + 4'(r_win[1] > CELL_EMPTY) +
                   4'(r_win[2] > CELL_EMPTY) + 4'(r_win[MID] > CELL_EMPTY) +
                   4'(r_win[MID+2] > CELL_EMPTY) + 4'(r_win[TOP] > CELL_EMPTY) +
                   4'(r_win[TOP+1] > CELL_EMPTY) + 4'(r_win[TOP+2] > CELL_EMPTY);
    end

    assign cur_cell = r_win[MID+1];
    assign c_int    = f_interior(CMP_W'(r_cc), CMP_W'(r_cr), r_aw, r_ah);
    assign nxt_cell = c_int ? f_next_cell(cur_cell, live_cnt) : CELL_EMPTY;

    // bank port steering: clear both, step writes the other bank, write op the current one
    always_comb begin
        if (clearing) begin
            waddr = r_clr_addr;
            wdata = CELL_EMPTY;
        end else if (r_s2_vld) begin
            waddr = r_caddr;
            wdata = nxt_cell;
        end else begin
            waddr = cell_addr;
            wdata = wr_val;
        end
        raddr = issue ? r_lead[AW-1:0] : cell_addr;
        we_a  = clearing || (cell_wr && !r_cur) || (r_s2_vld && r_cur);
        we_b  = clearing || (cell_wr && r_cur) || (r_s2_vld && !r_cur);
    end

    lfat_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_bank_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_a)
    );

    lfat_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_bank_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_b)
    );

    // result value of the command in work
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_int <= cell_int;
            r_res    <= CELL_EMPTY;
        end else if (rd_cap) begin
            r_res <= r_rd_int ? rdata_cur : CELL_EMPTY;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_val <= r_res;
            r_out_gen <= r_gen;
        end
    end

    assign o_s_tready = s_ready;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {5'd0, r_out_gen, r_out_val};

endmodule

>>> hdl/lfat_checker.sv
// Port-level checker for the fading-trail life block, bound to the top level.
// Depends on lfat_pkg.
`timescale 1ns / 1ps

module lfat_checker
    import lfat_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata
);

    // after reset: no result pending and no command ready
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready)
        else $error("result or ready seen right after reset");

    // one command in work: ready drops after every accepted beat
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second command accepted back to back");

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed under stall");

    // read_value stays in the cell range and the pad bits stay zero
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[2:0] != 3'd2 && o_m_tdata[2:0] != 3'd3 &&
                       o_m_tdata[M_TDATA_W-1:19] == '0)
        else $error("result beat out of range");

endmodule

bind life_automaton_with_fading_trail lfat_checker u_lfat_checker (.*);

>>> test/tb.sv
// Self-checking testbench for life_automaton_with_fading_trail: drives command beats,
// programs the APB size registers and checks every result beat against a grid predictor.
// Depends on lfat_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb
    import lfat_pkg::*;
();

    localparam int COLS        = DEF_GRID_COLS;
    localparam int ROWS        = DEF_GRID_ROWS;
    localparam int CELLS       = COLS * ROWS;
    localparam int RAND_ITEMS  = 100;
    localparam int DRAIN_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;

    // one result beat: read value and generation count
    typedef struct packed {
        logic signed [2:0] rd;
        logic [15:0]       gen;
    } result_t;

    // one row of the directed table: either a register write or a command beat
    typedef struct packed {
        bit                is_cfg;
        logic              reg_sel;
        logic [31:0]       cfg_data;
        t_op               op;
        logic [5:0]        col;
        logic [5:0]        row;
        logic [2:0]        val;
        bit                typed;
        logic signed [2:0] rd;
        logic [15:0]       gen;
    } plan_row_t;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    logic                 i_m_tready = 1'b0;
    logic                 psel       = 1'b0;
    logic                 penable    = 1'b0;
    logic                 pwrite     = 1'b0;
    logic [2:0]           paddr      = '0;
    logic [31:0]          pwdata     = '0;
    wire                  o_s_tready;
    wire                  o_m_tvalid;
    // [2:0] read_value, [18:3] generation, [23:19] zero
    wire [M_TDATA_W-1:0]  o_m_tdata;
    wire [31:0]           prdata;
    wire                  pready;

    // grid predictor state
    logic signed [2:0] cells [2][CELLS];
    bit                front_bank;
    logic [15:0]       gen_seen;
    int                act_w;
    int                act_h;

    result_t   pending_q [$];
    plan_row_t plan [$];
    int        fails;
    int        counted;
    int        phase;
    int        tx_gap_pct;
    int        rx_gap_pct;
    bit        hold_armed;
    bit        hold_done;
    int        hold_left;
    result_t   want;

    life_automaton_with_fading_trail DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #4 i_clk = ~i_clk;

    // hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic note_fail(input string msg);
        fails++;
        if (fails <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    // ---------------- grid predictor ----------------

    function automatic int clamp_dim(input logic [31:0] raw, input int hi);
        int x;
        x = int'(raw[6:0]);
        if (x < 3) begin
            x = 3;
        end
        if (x > hi) begin
            x = hi;
        end
        return x;
    endfunction

    function automatic bit is_inner(input int c, input int r);
        return c >= 1 && r >= 1 && c + 1 < act_w && r + 1 < act_h;
    endfunction

    function automatic int alive_at(input int c, input int r);
        if (!is_inner(c, r)) begin
            return 0;
        end
        return (cells[front_bank][r * COLS + c] > CELL_EMPTY) ? 1 : 0;
    endfunction

    task automatic clear_grid();
        int i;
        for (i = 0; i < CELLS; i++) begin
            cells[0][i] = CELL_EMPTY;
            cells[1][i] = CELL_EMPTY;
        end
        front_bank = 1'b0;
        gen_seen   = '0;
        act_w      = COLS;
        act_h      = ROWS;
    endtask

    // next generation into the back bank, which is wiped first
    task automatic step_generation();
        int                r;
        int                c;
        int                dr;
        int                dc;
        int                n;
        bit                dst;
        logic signed [2:0] cur;
        logic signed [2:0] nxt;
        dst = !front_bank;
        for (r = 0; r < CELLS; r++) begin
            cells[dst][r] = CELL_EMPTY;
        end
        for (r = 1; r + 1 < act_h; r++) begin
            for (c = 1; c + 1 < act_w; c++) begin
                n = 0;
                for (dr = -1; dr <= 1; dr++) begin
                    for (dc = -1; dc <= 1; dc++) begin
                        if (dr != 0 || dc != 0) begin
                            n += alive_at(c + dc, r + dr);
                        end
                    end
                end
                cur = cells[front_bank][r * COLS + c];
                nxt = (cur > TRAIL_FLOOR) ? cur - 3'sd1 : TRAIL_FLOOR;
                if (cur > CELL_EMPTY && (n == 2 || n == 3)) begin
                    nxt = CELL_ALIVE;
                end
                if (cur <= CELL_EMPTY && n == 3) begin
                    nxt = CELL_ALIVE;
                end
                cells[dst][r * COLS + c] = nxt;
            end
        end
        front_bank = dst;
        gen_seen   = gen_seen + 16'd1;
    endtask

    task automatic predict_cmd(input t_op op, input logic [5:0] col, input logic [5:0] row,
                               input logic [2:0] raw, output result_t res);
        logic signed [2:0] v;
        int                idx;
        v      = raw;
        idx    = int'(row) * COLS + int'(col);
        res.rd = CELL_EMPTY;
        case (op)
            OP_WRITE: begin
                if (v > CELL_ALIVE) begin
                    v = CELL_ALIVE;
                end
                if (is_inner(int'(col), int'(row))) begin
                    cells[front_bank][idx] = v;
                end
            end
            OP_READ: begin
                if (is_inner(int'(col), int'(row))) begin
                    res.rd = cells[front_bank][idx];
                end
            end
            OP_STEP: begin
                step_generation();
            end
            default: begin
            end
        endcase
        res.gen = gen_seen;
    endtask

    // ---------------- drivers ----------------

    task automatic set_traffic(input int ph);
        phase      = ph;
        tx_gap_pct = (ph == 0) ? 30 : (ph == 1) ? 68 : 0;
        rx_gap_pct = (ph == 0) ? 68 : (ph == 1) ? 30 : 0;
    endtask

    // offer one command beat; called right after a rising edge
    task automatic send_cmd(input t_op op, input logic [5:0] col, input logic [5:0] row,
                            input logic [2:0] val, input bit typed,
                            input logic signed [2:0] t_rd, input logic [15:0] t_gen);
        result_t res;
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'd0, val, row, col, op};
        do @(posedge i_clk); while (!o_s_tready);
        predict_cmd(op, col, row, val, res);
        if (typed) begin
            res.rd  = t_rd;
            res.gen = t_gen;
        end
        pending_q.push_back(res);
        if (op != OP_NONE) begin
            counted++;
        end
    endtask

    // any command at all, border and unused codes included
    task automatic send_any();
        send_cmd(t_op'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                 6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)), 1'b0, '0, '0);
    endtask

    // stop offering and wait until every expected beat is back
    task automatic drain_results();
        int waited;
        waited = 0;
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_q.size() != 0) begin
            note_fail($sformatf("%0d result beats never arrived", pending_q.size()));
            pending_q.delete();
        end
    endtask

    // setup and access cycle; register written at the access edge
    task automatic apb_write(input logic reg_sel, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_sel == REG_ACTIVE_WIDTH) begin
            act_w = clamp_dim(data, COLS);
        end else begin
            act_h = clamp_dim(data, ROWS);
        end
    endtask

    function automatic void plan_cmd(input t_op op, input logic [5:0] col,
                                     input logic [5:0] row, input logic [2:0] val,
                                     input bit typed, input logic signed [2:0] rd,
                                     input logic [15:0] gen);
        plan_row_t p;
        p          = '0;
        p.op       = op;
        p.col      = col;
        p.row      = row;
        p.val      = val;
        p.typed    = typed;
        p.rd       = rd;
        p.gen      = gen;
        plan.push_back(p);
    endfunction

    function automatic void plan_cfg(input logic reg_sel, input logic [31:0] data);
        plan_row_t p;
        p          = '0;
        p.is_cfg   = 1'b1;
        p.reg_sel  = reg_sel;
        p.cfg_data = data;
        plan.push_back(p);
    endfunction

    // one random episode: resize, seed a patch, step and read around it
    task automatic run_episode();
        logic [31:0] w_raw;
        logic [31:0] h_raw;
        int          pick;
        int          bc;
        int          br;
        int          sc;
        int          sr;
        int          n;
        int          k;
        int          j;
        pick = $urandom_range(0, 9);
        case (pick)
            0: begin
                w_raw = COLS;
                h_raw = ROWS;
            end
            1: begin
                w_raw = 3;
                h_raw = 3;
            end
            2: begin
                w_raw = $urandom;
                h_raw = $urandom_range(0, 2);
            end
            default: begin
                w_raw = $urandom_range(4, 12);
                h_raw = $urandom_range(4, 12);
            end
        endcase
        drain_results();
        apb_write(REG_ACTIVE_WIDTH, w_raw);
        apb_write(REG_ACTIVE_HEIGHT, h_raw);
        if (phase == 2) begin
            hold_armed = 1'b1;
        end
        // small areas are covered whole, one column and row past the border too
        sc = (act_w > 12) ? 9 : act_w;
        sr = (act_h > 12) ? 9 : act_h;
        bc = (act_w > 12) ? $urandom_range(0, 63 - sc) : 0;
        br = (act_h > 12) ? $urandom_range(0, 63 - sr) : 0;
        n  = $urandom_range(4, 12);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_any();
            end else begin
                send_cmd(OP_WRITE, 6'(bc + $urandom_range(0, sc)),
                         6'(br + $urandom_range(0, sr)),
                         3'(($urandom_range(0, 2) != 0) ? $urandom_range(1, 3)
                                                        : $urandom_range(0, 7)),
                         1'b0, '0, '0);
            end
        end
        n = $urandom_range(1, 2);
        for (k = 0; k < n; k++) begin
            send_cmd(OP_STEP, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                     3'($urandom_range(0, 7)), 1'b0, '0, '0);
            for (j = $urandom_range(2, 5); j > 0; j--) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_any();
                end else begin
                    send_cmd(OP_READ, 6'(bc + $urandom_range(0, sc)),
                             6'(br + $urandom_range(0, sr)),
                             3'($urandom_range(0, 7)), 1'b0, '0, '0);
                end
            end
        end
    endtask

    // ---------------- result side ----------------

    // ready with random stalls; one long hold-off once the last phase begins
    always @(posedge i_clk) begin
        if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= rx_gap_pct);
        end
    end

    // compare each accepted beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_q.size() == 0) begin
                note_fail($sformatf("unexpected result beat %h", o_m_tdata));
            end else begin
                want = pending_q.pop_front();
                if ($signed(o_m_tdata[2:0]) != want.rd || o_m_tdata[18:3] != want.gen) begin
                    note_fail($sformatf("result mismatch: read %0d gen %0d, expected %0d gen %0d",
                                        $signed(o_m_tdata[2:0]), o_m_tdata[18:3],
                                        want.rd, want.gen));
                end
            end
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        plan_row_t p;
        int        i;
        int        ph;
        fails      = 0;
        counted    = 0;
        hold_armed = 1'b0;
        hold_done  = 1'b0;
        hold_left  = 0;
        set_traffic(0);
        clear_grid();

        // fresh grid, unused code, border and far-corner cells
        plan_cmd(OP_READ,   6'd5,  6'd5,  3'd0,   1'b1, CELL_EMPTY, 16'd0);
        plan_cmd(OP_NONE,   6'd63, 6'd63, 3'b111, 1'b1, CELL_EMPTY, 16'd0);
        plan_cmd(OP_WRITE,  6'd63, 6'd63, 3'd1,   1'b1, CELL_EMPTY, 16'd0);
        plan_cmd(OP_READ,   6'd63, 6'd63, 3'd0,   1'b1, CELL_EMPTY, 16'd0);
        plan_cmd(OP_WRITE,  6'd0,  6'd0,  3'd1,   1'b1, CELL_EMPTY, 16'd0);
        plan_cmd(OP_READ,   6'd0,  6'd0,  3'd0,   1'b1, CELL_EMPTY, 16'd0);
        // too-large write value saturates to alive
        plan_cmd(OP_WRITE,  6'd1,  6'd1,  3'd3,   1'b1, CELL_EMPTY, 16'd0);
        plan_cmd(OP_READ,   6'd1,  6'd1,  3'd0,   1'b1, CELL_ALIVE, 16'd0);
        // vertical blinker, middle cell written with value two
        plan_cmd(OP_WRITE,  6'd10, 6'd9,  3'd1,   1'b1, CELL_EMPTY, 16'd0);
        plan_cmd(OP_WRITE,  6'd10, 6'd10, 3'd2,   1'b1, CELL_EMPTY, 16'd0);
        plan_cmd(OP_WRITE,  6'd10, 6'd11, 3'd1,   1'b1, CELL_EMPTY, 16'd0);
        // last interior cell, oldest trail then alive
        plan_cmd(OP_WRITE,  6'd62, 6'd62, TRAIL_FLOOR, 1'b1, CELL_EMPTY, 16'd0);
        plan_cmd(OP_READ,   6'd62, 6'd62, 3'd0,   1'b1, TRAIL_FLOOR, 16'd0);
        plan_cmd(OP_WRITE,  6'd62, 6'd62, CELL_ALIVE, 1'b1, CELL_EMPTY, 16'd0);
        plan_cmd(OP_STEP,   6'd0,  6'd0,  3'd0,   1'b1, CELL_EMPTY, 16'd1);
        plan_cmd(OP_READ,   6'd9,  6'd10, 3'd0,   1'b0, '0, '0);
        plan_cmd(OP_READ,   6'd10, 6'd9,  3'd0,   1'b0, '0, '0);
        plan_cmd(OP_READ,   6'd1,  6'd1,  3'd0,   1'b0, '0, '0);
        plan_cmd(OP_READ,   6'd62, 6'd62, 3'd0,   1'b0, '0, '0);
        // shrink below the minimum: only cell (1,1) is interior
        plan_cfg(REG_ACTIVE_WIDTH,  32'd130);
        plan_cfg(REG_ACTIVE_HEIGHT, 32'd0);
        plan_cmd(OP_READ,   6'd1,  6'd1,  3'd0,   1'b0, '0, '0);
        plan_cmd(OP_STEP,   6'd63, 6'd63, 3'b111, 1'b1, CELL_EMPTY, 16'd2);
        plan_cmd(OP_READ,   6'd10, 6'd10, 3'd0,   1'b1, CELL_EMPTY, 16'd2);
        // grow past the maximum again; stale cells stay cleared
        plan_cfg(REG_ACTIVE_WIDTH,  32'hFFFF_FFFF);
        plan_cfg(REG_ACTIVE_HEIGHT, 32'd200);
        plan_cmd(OP_READ,   6'd10, 6'd10, 3'd0,   1'b0, '0, '0);
        plan_cmd(OP_STEP,   6'd0,  6'd0,  3'd0,   1'b1, CELL_EMPTY, 16'd3);
        plan_cmd(OP_READ,   6'd11, 6'd10, 3'd0,   1'b0, '0, '0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < plan.size(); i++) begin
            p = plan[i];
            if (p.is_cfg) begin
                drain_results();
                apb_write(p.reg_sel, p.cfg_data);
            end else begin
                send_cmd(p.op, p.col, p.row, p.val, p.typed, p.rd, p.gen);
            end
        end

        // random episodes, traffic pattern changes by thirds
        counted = 0;
        while (counted < RAND_ITEMS) begin
            ph = (counted < RAND_ITEMS / 3) ? 0 : (counted < 2 * RAND_ITEMS / 3) ? 1 : 2;
            if (ph != phase) begin
                set_traffic(ph);
            end
            run_episode();
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (fails == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
